>>> hdl/slvn_pkg.sv
// ----------------------------------------------------------------------------
// slvn_pkg
// Shared constants and types for the smoothed lattice value noise block.
// ----------------------------------------------------------------------------
package slvn_pkg;

  // integer noise hash constants, all arithmetic mod 2^32
  localparam logic [31:0] HASH_Z_MUL  = 32'd57;
  localparam int unsigned HASH_SHIFT  = 13;
  localparam logic [31:0] HASH_C1     = 32'd15731;
  localparam logic [31:0] HASH_C2     = 32'd3263443;
  localparam logic [31:0] HASH_C3     = 32'd1376312589;

  // value of a point is 2^31 - h, in units of 2^-31
  localparam logic [31:0] VALUE_ONE   = 32'h8000_0000;

  // lattice points per item: four corners, four sides, one centre
  localparam int unsigned NUM_POINTS  = 9;
  localparam int unsigned IDX_CENTRE  = 8;

  // result width and range
  localparam int unsigned SUM_W       = 36;
  localparam int unsigned PART_W      = 34;
  localparam logic [SUM_W-1:0] SUM_MIN = 36'd16;
  localparam logic [SUM_W-1:0] SUM_MAX = 36'h8_0000_0000;

  // load enables for the four hash pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } hash_en_t;

endpackage

>>> hdl/slvn_if.sv
// ----------------------------------------------------------------------------
// slvn_in_if / slvn_out_if
// Valid/ready channels carrying a lattice point in and a noise value out.
// ----------------------------------------------------------------------------
interface slvn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lattice_x;
  logic signed [31:0] lattice_z;

  modport source (output valid, output lattice_x, output lattice_z, input ready);
  modport sink   (input valid, input lattice_x, input lattice_z, output ready);
endinterface

interface slvn_out_if;
  logic        valid;
  logic        ready;
  logic [35:0] smoothed_value;

  modport source (output valid, output smoothed_value, input ready);
  modport sink   (input valid, input smoothed_value, output ready);
endinterface

>>> hdl/slvn_hash.sv
// ----------------------------------------------------------------------------
// slvn_hash
// Four-stage pipelined integer noise hash of one lattice point.
// ----------------------------------------------------------------------------
module slvn_hash (
  input  logic              clk,
  input  slvn_pkg::hash_en_t en,
  input  logic [31:0]       px,
  input  logic [31:0]       pz,
  output logic [30:0]       hash
);
  import slvn_pkg::*;

  logic [31:0] lin;
  logic [31:0] n_nxt;
  logic [31:0] n1_r, n2_r, n3_r;
  logic [31:0] sq_nxt, sq_r;
  logic [31:0] poly_nxt, poly_r;
  logic [31:0] full_nxt;
  logic [30:0] hash_r;

  // stage 1: linear combination and shift-xor mix
  assign lin   = px + pz * HASH_Z_MUL;
  assign n_nxt = lin ^ (lin << HASH_SHIFT);

  // stage 2: square
  assign sq_nxt = n1_r * n1_r;

  // stage 3: inner polynomial
  assign poly_nxt = sq_r * HASH_C1 + HASH_C2;

  // stage 4: outer product, offset and mask to 31 bits
  assign full_nxt = n3_r * poly_r + HASH_C3;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      n1_r <= n_nxt;
    end
    if (en.s2) begin
      n2_r <= n1_r;
      sq_r <= sq_nxt;
    end
    if (en.s3) begin
      n3_r   <= n2_r;
      poly_r <= poly_nxt;
    end
    if (en.s4) begin
      hash_r <= full_nxt[30:0];
    end
  end

  assign hash = hash_r;

endmodule

>>> hdl/smoothed_lattice_value_noise_2d.sv
// ----------------------------------------------------------------------------
// smoothed_lattice_value_noise_2d
// Smoothed 2D integer value noise: nine hashed lattice values, weighted sum.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one lattice point (lattice_x, lattice_z) per beat, and
//   out_chan returns one smoothed_value per beat, unsigned with 35 fraction
//   bits, in the order the points went in.
//   The point and its eight wrapped neighbours are hashed in nine parallel
//   hash pipelines (mix, square, polynomial, product), then summed with
//   weights 1/16 corner, 1/8 side, 1/4 centre over two more stages.
//   When nothing stalls, one beat is accepted every cycle.
//   The six stages each carry a valid bit; a stage loads whenever it is
//   empty or the stage after it moves, so bubbles are squeezed out.
//   When the receiver holds out_chan.ready low the result stays on the port
//   and the stages behind it keep filling until the pipeline is full, then
//   in_chan.ready drops; nothing is lost or repeated.
//   Synchronous active-low reset empties the pipeline; there is no
//   configuration and no other state.
// ----------------------------------------------------------------------------
module smoothed_lattice_value_noise_2d (
  input  logic        clk,
  input  logic        rst_n,
  slvn_in_if.sink     in_chan,
  slvn_out_if.source  out_chan
);
  import slvn_pkg::*;

  localparam int unsigned NUM_STAGES = 6;

  logic [NUM_STAGES:1] vld_r, vld_nxt;
  logic [NUM_STAGES:1] rdy;
  hash_en_t            hash_en;

  logic [31:0] x, z, xm, xp, zm, zp;
  logic [31:0] px [NUM_POINTS];
  logic [31:0] pz [NUM_POINTS];
  logic [30:0] hash [NUM_POINTS];
  logic [31:0] val [NUM_POINTS];

  logic [PART_W-1:0] corners_nxt, sides_nxt;
  logic [PART_W-1:0] corners_r, sides_r;
  logic [31:0]       centre_r;
  logic [SUM_W-1:0]  sum_nxt, sum_r;

  // ready chain, last stage first
  always_comb begin
    rdy[NUM_STAGES] = out_chan.ready || !vld_r[NUM_STAGES];
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = rdy[k+1] || !vld_r[k];
    end
  end

  // valid bits move with the data
  always_comb begin
    vld_nxt = vld_r;
    if (rdy[1]) begin
      vld_nxt[1] = in_chan.valid;
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_chan.ready = rdy[1];
  assign hash_en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4]};

  // neighbour coordinates, wrapping mod 2^32
  assign x  = in_chan.lattice_x;
  assign z  = in_chan.lattice_z;
  assign xm = x - 32'd1;
  assign xp = x + 32'd1;
  assign zm = z - 32'd1;
  assign zp = z + 32'd1;

  // point order: corners, sides, centre
  always_comb begin
    px[0] = xm; pz[0] = zm;
    px[1] = xp; pz[1] = zm;
    px[2] = xm; pz[2] = zp;
    px[3] = xp; pz[3] = zp;
    px[4] = xp; pz[4] = z;
    px[5] = xm; pz[5] = z;
    px[6] = x;  pz[6] = zp;
    px[7] = x;  pz[7] = zm;
    px[IDX_CENTRE] = x;
    pz[IDX_CENTRE] = z;
  end

  // nine hash pipelines, stages 1 to 4
  for (genvar i = 0; i < NUM_POINTS; i++) begin : g_hash
    slvn_hash u_hash (
      .clk  (clk),
      .en   (hash_en),
      .px   (px[i]),
      .pz   (pz[i]),
      .hash (hash[i])
    );
    assign val[i] = VALUE_ONE - {1'b0, hash[i]};
  end

  // stage 5: corner and side partial sums
  assign corners_nxt = PART_W'(val[0]) + PART_W'(val[1]) + PART_W'(val[2])
                     + PART_W'(val[3]);
  assign sides_nxt   = PART_W'(val[4]) + PART_W'(val[5]) + PART_W'(val[6])
                     + PART_W'(val[7]);

  // stage 6: weighted total, output register
  assign sum_nxt = SUM_W'(corners_r) + (SUM_W'(sides_r) << 1)
                 + (SUM_W'(centre_r) << 2);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      corners_r <= corners_nxt;
      sides_r   <= sides_nxt;
      centre_r  <= val[IDX_CENTRE];
    end
    if (rdy[6]) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_chan.valid          = vld_r[NUM_STAGES];
  assign out_chan.smoothed_value = sum_r;

`ifndef SYNTHESIS
  // a free receiver frees the whole pipeline
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input stalled while receiver ready");

  // result lies in the range of a weighted sum of nine values in (0,1]
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (sum_r >= SUM_MIN) && (sum_r <= SUM_MAX))
    else $error("smoothed value out of range");

  // a stalled stage keeps its beat
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && !rdy[5] |=> vld_r[4])
    else $error("stalled hash beat dropped");

  // an output stage that was empty holds exactly what stage 5 held
  a_stage_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NUM_STAGES] |=> vld_r[NUM_STAGES] == $past(vld_r[5]))
    else $error("beat lost between sum stages");
`endif

endmodule
